>>> design/lru_block_buffer_cache_tags_defines.svh
// assertion macros for the buffer cache tag manager
`ifndef LRU_BLOCK_BUFFER_CACHE_TAGS_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_TAGS_DEFINES_SVH
// check that a condition implies a property on the same edge
`define LBC_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// check that a condition implies a property on the next edge
`define LBC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

>>> design/lbc_pkg.sv
// shared types and constants for the buffer cache tag manager
package lbc_pkg;
   localparam int DefNumBuffers = 32;
   typedef enum logic [1:0] {
      CMD_GET = 2'd0, CMD_RELEASE = 2'd1, CMD_PIN = 2'd2, CMD_UNPIN = 2'd3
   } cmd_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_NO_FREE = 2'd1, ST_UNDERFLOW = 2'd2, ST_OVERFLOW = 2'd3
   } status_type;
   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  device_id;
      logic [31:0] block_number;
      logic [4:0]  buffer_slot;
   } req_type;
   typedef struct packed {
      logic [4:0]  slot_out;
      logic        hit;
      logic        need_read;
      status_type  status;
   } rsp_type;
endpackage

>>> design/lbc_if.sv
// valid/ready channel carrying one word
interface lbc_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

>>> design/lbc_front.sv
// front: accepts request words into a short queue
module lbc_front (
   input logic clock,
   input logic reset,
   lbc_if.sink req,
   output lbc_pkg::req_type q_word,
   output logic q_valid,
   input logic q_take
);
   import lbc_pkg::*;
   req_type q_ff [2];
   req_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push;
   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word = q_ff[0];
   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (q_take && q_valid) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = req.word;
         cnt_in = cnt_in + 2'd1;
      end
   end
   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end
endmodule

>>> design/lbc_back.sv
// back: scans buffer tags over cycles and applies one command
module lbc_back #(parameter int NumBuffers = lbc_pkg::DefNumBuffers) (
   input logic clock,
   input logic reset,
   input lbc_pkg::req_type q_word,
   input logic q_valid,
   output logic q_take,
   lbc_if.source rsp
);
   import lbc_pkg::*;
   localparam int IW = $clog2(NumBuffers);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_FREE = 5'b00100,
      S_AGE = 5'b01000, S_OUT = 5'b10000
   } state_type;
   state_type st_ff, st_in;
   logic [7:0]  tdev_ff [NumBuffers];
   logic [31:0] tblk_ff [NumBuffers];
   logic [NumBuffers-1:0] vld_ff;
   logic [7:0]  cnt_ff [NumBuffers];
   logic [IW-1:0] age_ff [NumBuffers];
   logic [IW:0] idx_ff;
   logic [IW-1:0] best_ff;
   logic found_ff;
   logic [IW-1:0] old_ff;
   rsp_type out_ff;
   logic [IW-1:0] i;
   logic [IW-1:0] sl;
   assign i = idx_ff[IW-1:0];
   assign sl = IW'(q_word.buffer_slot);
   logic slot_ok;
   assign slot_ok = ({27'd0, q_word.buffer_slot} < 32'(NumBuffers));
   assign rsp.valid = (st_ff == S_OUT);
   assign rsp.word = out_ff;
   assign q_take = (st_ff == S_OUT) && rsp.ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         vld_ff <= '0;
         for (int k = 0; k < NumBuffers; k++) begin
            tdev_ff[k] <= '0;
            tblk_ff[k] <= '0;
            cnt_ff[k] <= '0;
            age_ff[k] <= IW'(NumBuffers - 1 - k);
         end
      end else begin
         unique case (st_ff)
            S_IDLE: if (q_valid) begin
               idx_ff <= '0;
               found_ff <= 1'b0;
               out_ff <= '{slot_out: q_word.buffer_slot, hit: 1'b0,
                           need_read: 1'b0, status: ST_OK};
               if (q_word.cmd == CMD_GET) st_ff <= S_SCAN;
               else begin
                  st_ff <= S_OUT;
                  if (slot_ok) begin
                     if (q_word.cmd == CMD_PIN) begin
                        if (cnt_ff[sl] == 8'hff) out_ff.status <= ST_OVERFLOW;
                        else cnt_ff[sl] <= cnt_ff[sl] + 8'd1;
                     end else if (cnt_ff[sl] == 8'd0) out_ff.status <= ST_UNDERFLOW;
                     else begin
                        cnt_ff[sl] <= cnt_ff[sl] - 8'd1;
                        if (q_word.cmd == CMD_RELEASE && cnt_ff[sl] == 8'd1) begin
                           old_ff <= age_ff[sl];
                           best_ff <= sl;
                           st_ff <= S_AGE;
                        end
                     end
                  end
               end
            end
            S_SCAN: begin
               if (tdev_ff[i] == q_word.device_id && tblk_ff[i] == q_word.block_number
                   && (!found_ff || age_ff[i] < age_ff[best_ff])) begin
                  found_ff <= 1'b1;
                  best_ff <= i;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == (IW+1)'(NumBuffers - 1)) begin
                  idx_ff <= '0;
                  st_ff <= S_FREE;
               end
            end
            S_FREE: begin
               if (out_ff.hit || idx_ff == '0 && found_ff) begin
                  // hit: apply on entry, without a free scan
                  out_ff.hit <= 1'b1;
                  out_ff.slot_out <= 5'(best_ff);
                  out_ff.need_read <= !vld_ff[best_ff];
                  vld_ff[best_ff] <= 1'b1;
                  if (cnt_ff[best_ff] == 8'hff) out_ff.status <= ST_OVERFLOW;
                  else cnt_ff[best_ff] <= cnt_ff[best_ff] + 8'd1;
                  st_ff <= S_OUT;
               end else begin
                  if (idx_ff == '0) found_ff <= 1'b0;
                  if (cnt_ff[i] == 8'd0 &&
                      (idx_ff == '0 || !found_ff || age_ff[i] > age_ff[best_ff])) begin
                     found_ff <= 1'b1;
                     best_ff <= i;
                  end
                  idx_ff <= idx_ff + 1'b1;
                  if (idx_ff == (IW+1)'(NumBuffers)) begin
                     st_ff <= S_OUT;
                     if (!found_ff) begin
                        out_ff <= '{slot_out: 5'd0, hit: 1'b0, need_read: 1'b0,
                                    status: ST_NO_FREE};
                     end else begin
                        out_ff.slot_out <= 5'(best_ff);
                        out_ff.need_read <= 1'b1;
                        tdev_ff[best_ff] <= q_word.device_id;
                        tblk_ff[best_ff] <= q_word.block_number;
                        vld_ff[best_ff] <= 1'b1;
                        cnt_ff[best_ff] <= 8'd1;
                     end
                  end
               end
            end
            S_AGE: begin
               for (int k = 0; k < NumBuffers; k++)
                  if (age_ff[k] < old_ff) age_ff[k] <= age_ff[k] + 1'b1;
               age_ff[best_ff] <= '0;
               st_ff <= S_OUT;
            end
            S_OUT: if (rsp.ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
   `include "lru_block_buffer_cache_tags_defines.svh"
   `LBC_ASSERT_IMP(a_take_out, clock, reset, q_take, rsp.valid && q_valid)
   `LBC_ASSERT_NEXT(a_out_idle, clock, reset, rsp.valid && rsp.ready, st_ff == S_IDLE)
   `LBC_ASSERT_NEXT(a_age_out, clock, reset, st_ff == S_AGE, st_ff == S_OUT)
endmodule

>>> design/lru_block_buffer_cache_tags.sv
// top level of the buffer cache tag manager
// channel | dir | word
// req     | in  | cmd, device_id, block_number, buffer_slot
// rsp     | out | slot_out, hit, need_read, status
// get: a tag scan, then on a miss a free scan
// release/pin/unpin: a release to zero adds an age update step
// a two-word request queue lets req accept one more word while rsp stalls
// synchronous reset clears all tags and counts at once and sets age k to NUM_BUFFERS-1-k
module lru_block_buffer_cache_tags #(parameter int NUM_BUFFERS = lbc_pkg::DefNumBuffers) (
   input logic clock,
   input logic reset,
   lbc_if.sink req,
   lbc_if.source rsp
);
   import lbc_pkg::*;
   req_type q_word;
   logic q_valid, q_take;
   lbc_front u_front (.clock, .reset, .req, .q_word, .q_valid, .q_take);
   lbc_back #(.NumBuffers(NUM_BUFFERS)) u_back (.clock, .reset, .q_word, .q_valid,
      .q_take, .rsp);
endmodule

>>> tb/sv/tb_lbc_if.sv
// stall control interface for the testbench
interface tb_stall_if ();
   logic hold;
endinterface

>>> tb/sv/tb_top.sv
// testbench for the buffer cache tag manager: predicts each result and checks it in order
module tb_top;
   import lbc_pkg::*;

   localparam int NB = DefNumBuffers;

   logic clock;
   logic reset;
   lbc_if #(.word_type(req_type)) req ();
   lbc_if #(.word_type(rsp_type)) rsp ();
   tb_stall_if stall ();

   lru_block_buffer_cache_tags #(.NUM_BUFFERS(NB)) dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   class cache_scoreboard;
      logic [7:0]  tag_dev [NB];
      logic [31:0] tag_blk [NB];
      bit          valid_q [NB];
      logic [7:0]  count_q [NB];
      int          age_q [NB];
      rsp_type     pending [$];
      int          errors;

      function void clear();
         for (int i = 0; i < NB; i++) begin
            tag_dev[i] = '0;
            tag_blk[i] = '0;
            valid_q[i] = 0;
            count_q[i] = '0;
            age_q[i] = NB - 1 - i;
         end
         errors = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type o;
         int f;
         int old;
         o = '0;
         o.status = ST_OK;
         f = -1;
         if (r.cmd == CMD_GET) begin
            for (int i = 0; i < NB; i++)
               if (tag_dev[i] == r.device_id && tag_blk[i] == r.block_number)
                  if (f < 0 || age_q[i] < age_q[f]) f = i;
            if (f >= 0) begin
               o.hit = 1;
               if (count_q[f] == 8'hff) o.status = ST_OVERFLOW;
               else count_q[f]++;
            end else begin
               for (int i = 0; i < NB; i++)
                  if (count_q[i] == 0)
                     if (f < 0 || age_q[i] > age_q[f]) f = i;
               if (f >= 0) begin
                  tag_dev[f] = r.device_id;
                  tag_blk[f] = r.block_number;
                  valid_q[f] = 0;
                  count_q[f] = 8'd1;
               end
            end
            if (f < 0) begin
               o.status = ST_NO_FREE;
            end else begin
               o.slot_out = f[4:0];
               o.need_read = !valid_q[f];
               valid_q[f] = 1;
            end
         end else begin
            o.slot_out = r.buffer_slot;
            if (r.buffer_slot < NB) begin
               if (r.cmd == CMD_PIN) begin
                  if (count_q[r.buffer_slot] == 8'hff) o.status = ST_OVERFLOW;
                  else count_q[r.buffer_slot]++;
               end else if (count_q[r.buffer_slot] == 0) begin
                  o.status = ST_UNDERFLOW;
               end else begin
                  count_q[r.buffer_slot]--;
                  if (r.cmd == CMD_RELEASE && count_q[r.buffer_slot] == 0) begin
                     old = age_q[r.buffer_slot];
                     for (int i = 0; i < NB; i++)
                        if (age_q[i] < old) age_q[i]++;
                     age_q[r.buffer_slot] = 0;
                  end
               end
            end
         end
         pending.push_back(o);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", a);
            return;
         end
         e = pending.pop_front();
         if (a.slot_out !== e.slot_out || a.hit !== e.hit ||
             a.need_read !== e.need_read || a.status !== e.status) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected slot %0d hit %b need %b st %0d, got %0d %b %b %0d",
                  e.slot_out, e.hit, e.need_read, e.status,
                  a.slot_out, a.hit, a.need_read, a.status);
         end
      endfunction
   endclass

   cache_scoreboard board;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAIL lru_block_buffer_cache_tags");
      $finish;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   task automatic send_word(req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.word <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(r);
   endtask

   function automatic req_type make_word(cmd_type c, logic [7:0] d, logic [31:0] b,
                                         logic [4:0] s);
      req_type r;
      r.cmd = c;
      r.device_id = d;
      r.block_number = b;
      r.buffer_slot = s;
      return r;
   endfunction

   function automatic req_type random_word();
      int k;
      k = $urandom_range(0, 9);
      if (k < 4)
         return make_word(CMD_GET, 8'($urandom_range(0, 3)), 32'($urandom_range(0, 15)),
                          5'($urandom));
      if (k == 4)
         return make_word(CMD_GET, 8'($urandom), 32'($urandom), 5'($urandom));
      return make_word(cmd_type'($urandom_range(1, 3)), 8'($urandom), 32'($urandom),
                       5'($urandom_range(0, 31)));
   endfunction

   // receiver side: random stalls plus one long hold
   initial begin
      int gap;
      rsp.ready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall.hold) begin
            rsp.ready <= 0;
         end else begin
            gap = pick_gap();
            if (gap > 0 && !rsp.ready) begin
               repeat (gap - 1) @(posedge clock);
               rsp.ready <= 1;
            end else begin
               rsp.ready <= (gap == 0) || !rsp.ready || $urandom_range(0, 1);
            end
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp.valid && rsp.ready) board.check_result(rsp.word);

   initial begin
      int waited;
      board = new();
      board.clear();
      stall.hold = 0;
      reset <= 1;
      req.valid <= 0;
      req.word <= '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: initial tags, extremes, each command
      send_word(make_word(CMD_GET, 8'd0, 32'd0, 5'd0));
      send_word(make_word(CMD_GET, 8'hff, 32'hffff_ffff, 5'd31));
      send_word(make_word(CMD_GET, 8'hff, 32'hffff_ffff, 5'd0));
      send_word(make_word(CMD_RELEASE, 8'd0, 32'd0, 5'd0));
      send_word(make_word(CMD_UNPIN, 8'd0, 32'd0, 5'd5));
      send_word(make_word(CMD_PIN, 8'd0, 32'd0, 5'd31));
      send_word(make_word(CMD_UNPIN, 8'd0, 32'd0, 5'd31));
      send_word(make_word(CMD_RELEASE, 8'd0, 32'd0, 5'd31));
      send_word(make_word(CMD_RELEASE, 8'd0, 32'd0, 5'd30));
      // drive one count to full and overflow it via pin, then two gets
      for (int i = 0; i < 256; i++) send_word(make_word(CMD_PIN, 8'd0, 32'd0, 5'd3));
      send_word(make_word(CMD_PIN, 8'd0, 32'd0, 5'd3));
      send_word(make_word(CMD_GET, 8'd0, 32'd0, 5'd0));
      send_word(make_word(CMD_GET, 8'd0, 32'd0, 5'd0));
      // no free buffer: pin everything, then a miss
      for (int i = 0; i < NB; i++) send_word(make_word(CMD_PIN, 8'd0, 32'd0, 5'(i)));
      send_word(make_word(CMD_GET, 8'h5a, 32'h1234_5678, 5'd0));
      for (int i = 0; i < NB; i++) send_word(make_word(CMD_RELEASE, 8'd0, 32'd0, 5'(i)));
      for (int i = 0; i < NB; i++) send_word(make_word(CMD_UNPIN, 8'd0, 32'd0, 5'(i)));
      // long receiver hold while requests keep coming
      fork
         begin
            stall.hold = 1;
            repeat (400) @(posedge clock);
            stall.hold = 0;
         end
         for (int i = 0; i < 12; i++) send_word(random_word());
      join
      for (int i = 0; i < 1650; i++) send_word(random_word());
      req.valid <= 0;
      waited = 0;
      while (board.pending.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS lru_block_buffer_cache_tags");
      else
         $display("FAIL lru_block_buffer_cache_tags");
      $finish;
   end
endmodule
